/* rtl/core/nps_pkg.sv */
// Shared types and constants for the nearest point search core.
// Used by the controller, the datapath and the top level; depends on nothing.
package nps_pkg;

	localparam int POS_BITS       = 16;
	localparam int SLOT_PORT_BITS = 8;
	localparam int FLAG_PORT_BITS = 16;
	localparam int MAXD_BITS      = 16;
	localparam int DIST_PORT_BITS = 34;
	localparam int COORD_MAX_BITS = 24;
	localparam int FLAG_MAX_BITS  = 32;

	localparam logic [DIST_PORT_BITS-1:0] DEFAULT_LIMIT_SQ = 34'd9999800001;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic clear_wr;
		logic item_wr;
		logic query_load;
		logic scan_rd;
		logic scan_last;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;

endpackage

/* rtl/core/nearest_point_search_core.sv */
// Top level of the nearest point search core: joins controller and datapath.
// Depends on nps_pkg, nps_ctrl, nps_datapath and nps_ram.
//
// Channel   Direction  Handshake           Word
// input     in         start and not busy  mode, slot, present, pos_x/y/z, flags, mask,
//                                          max_distance
// result    out        done, one cycle     found, best_slot, best_dist_sq
//
// A write word leaves busy low and gives no result.
// A query reads one table slot per cycle through the table RAM read port and
// raises done once the last slot has left the distance pipeline; busy falls after done.
// After reset a clearing pass over every table slot holds busy high.
// The receiver cannot stall; each result holds on the outputs from its done cycle until the next query is taken.
module nearest_point_search_core #(
	parameter int NUM_POINTS = 256,
	parameter int COORD_BITS = 16,
	parameter int FLAG_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [nps_pkg::SLOT_PORT_BITS-1:0]  slot,
	input  logic                                present,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_x,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_y,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_z,
	input  logic [nps_pkg::FLAG_PORT_BITS-1:0]  flags,
	input  logic [nps_pkg::FLAG_PORT_BITS-1:0]  mask,
	input  logic [nps_pkg::MAXD_BITS-1:0]       max_distance,
	output logic                                done,
	output logic                                found,
	output logic [nps_pkg::SLOT_PORT_BITS-1:0]  best_slot,
	output logic [nps_pkg::DIST_PORT_BITS-1:0]  best_dist_sq
);

	nps_pkg::cmd_t                 cmd;
	nps_pkg::status_t              status;
	logic [$clog2(NUM_POINTS)-1:0] index;

	nps_ctrl #(
		.NUM_POINTS (NUM_POINTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.cmd    (cmd),
		.index  (index),
		.busy   (busy),
		.done   (done)
	);

	nps_datapath #(
		.NUM_POINTS (NUM_POINTS),
		.COORD_BITS (COORD_BITS),
		.FLAG_BITS  (FLAG_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.index        (index),
		.status       (status),
		.slot         (slot),
		.present      (present),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.flags        (flags),
		.mask         (mask),
		.max_distance (max_distance),
		.found        (found),
		.best_slot    (best_slot),
		.best_dist_sq (best_dist_sq)
	);

endmodule

/* rtl/core/nps_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; depends on nothing.
module nps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/nps_ctrl.sv */
// Controller state machine: clearing pass, item acceptance, slot scan and result strobe.
// Depends on nps_pkg for the command and status structs and the mode codes.
module nps_ctrl #(
	parameter int NUM_POINTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          mode,
	input  nps_pkg::status_t              status,
	output nps_pkg::cmd_t                 cmd,
	output logic [$clog2(NUM_POINTS)-1:0] index,
	output logic                          busy,
	output logic                          done
);

	localparam int IDX_W = $clog2(NUM_POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             cnt_last;

	assign cnt_last = (cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start && mode == nps_pkg::MODE_QUERY) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (status.scan_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.clear_wr   = (state_q == ST_CLEAR);
		cmd.item_wr    = (state_q == ST_IDLE) && start && (mode == nps_pkg::MODE_WRITE);
		cmd.query_load = (state_q == ST_IDLE) && start && (mode == nps_pkg::MODE_QUERY);
		cmd.scan_rd    = (state_q == ST_SCAN);
		cmd.scan_last  = (state_q == ST_SCAN) && cnt_last;
	end

	assign index = cnt_q;
	assign busy  = (state_q != ST_IDLE);
	assign done  = (state_q == ST_DONE);

endmodule

/* rtl/core/nps_datapath.sv */
// Datapath: point table, query registers, distance pipeline and best-match tracking.
// Depends on nps_pkg and instantiates nps_ram.
module nps_datapath #(
	parameter int NUM_POINTS = 256,
	parameter int COORD_BITS = 16,
	parameter int FLAG_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nps_pkg::cmd_t                       cmd,
	input  logic [$clog2(NUM_POINTS)-1:0]       index,
	output nps_pkg::status_t                    status,
	input  logic [nps_pkg::SLOT_PORT_BITS-1:0]  slot,
	input  logic                                present,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_x,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_y,
	input  logic signed [nps_pkg::POS_BITS-1:0] pos_z,
	input  logic [nps_pkg::FLAG_PORT_BITS-1:0]  flags,
	input  logic [nps_pkg::FLAG_PORT_BITS-1:0]  mask,
	input  logic [nps_pkg::MAXD_BITS-1:0]       max_distance,
	output logic                                found,
	output logic [nps_pkg::SLOT_PORT_BITS-1:0]  best_slot,
	output logic [nps_pkg::DIST_PORT_BITS-1:0]  best_dist_sq
);

	localparam int IDX_W  = $clog2(NUM_POINTS);
	localparam int C      = COORD_BITS;
	localparam int WORD_W = 3 * C + FLAG_BITS + 1;
	localparam int SUM_W  = 2 * C + 2;
	localparam int DIST_W = (SUM_W > nps_pkg::DIST_PORT_BITS) ? SUM_W : nps_pkg::DIST_PORT_BITS;

	// Coordinate and flag fields as the table stores them.
	logic [2:0][nps_pkg::COORD_MAX_BITS-1:0] pos_ext;
	logic [2:0][C-1:0]                       pos_c;
	logic [nps_pkg::FLAG_MAX_BITS-1:0]       flags_ext;
	logic [nps_pkg::FLAG_MAX_BITS-1:0]       mask_ext;
	logic [31:0]                             slot_ext;
	logic [31:0]                             maxd_sq;

	always_comb begin
		pos_ext[0] = nps_pkg::COORD_MAX_BITS'($unsigned(pos_x));
		pos_ext[1] = nps_pkg::COORD_MAX_BITS'($unsigned(pos_y));
		pos_ext[2] = nps_pkg::COORD_MAX_BITS'($unsigned(pos_z));
		for (int k = 0; k < 3; k++) begin
			pos_c[k] = pos_ext[k][C-1:0];
		end
	end

	assign flags_ext = nps_pkg::FLAG_MAX_BITS'(flags);
	assign mask_ext  = nps_pkg::FLAG_MAX_BITS'(mask);
	assign slot_ext  = 32'(slot);
	assign maxd_sq   = 32'(max_distance) * 32'(max_distance);

	// Table write port: clearing pass or one write word.
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = index;
		ram_wdata = '0;
		if (cmd.clear_wr) begin
			ram_we = 1'b1;
		end else if (cmd.item_wr && (slot_ext < NUM_POINTS)) begin
			ram_we    = 1'b1;
			ram_waddr = slot_ext[IDX_W-1:0];
			ram_wdata = {present, flags_ext[FLAG_BITS-1:0], pos_c[2], pos_c[1], pos_c[0]};
		end
	end

	nps_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.scan_rd),
		.raddr (index),
		.rdata (ram_rdata)
	);

	// Query registers.
	logic [2:0][C-1:0]    qpos_q;
	logic [FLAG_BITS-1:0] qmask_q;
	logic [DIST_W-1:0]    limit_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [nps_pkg::DIST_PORT_BITS-1:0] best_d_q;

	// Pipeline control.
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             last_s1, last_s2, last_s3, last_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic             ok_s2, ok_s3, ok_s4;
	logic [2:0][C-1:0]   mag_s2;
	logic [2:0][2*C-1:0] sq_s3;
	logic [DIST_W-1:0]   sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
			last_s4 <= 1'b0;
		end else begin
			v_s1    <= cmd.scan_rd;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			last_s1 <= cmd.scan_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
		end
	end

	// Stage 1: table word is at the RAM output; form absolute differences.
	logic [2:0][C-1:0] pt_c;
	logic [2:0][C:0]   diff_s1;
	logic [2:0][C:0]   neg_s1;
	logic [2:0][C-1:0] mag_s1;
	logic [FLAG_BITS-1:0] pt_flags;
	logic              pt_present;
	logic              ok_s1;

	always_comb begin
		pt_c[0]    = ram_rdata[0 +: C];
		pt_c[1]    = ram_rdata[C +: C];
		pt_c[2]    = ram_rdata[2*C +: C];
		pt_flags   = ram_rdata[3*C +: FLAG_BITS];
		pt_present = ram_rdata[WORD_W-1];
		for (int k = 0; k < 3; k++) begin
			diff_s1[k] = {pt_c[k][C-1], pt_c[k]} - {qpos_q[k][C-1], qpos_q[k]};
			neg_s1[k]  = '0 - diff_s1[k];
			mag_s1[k]  = diff_s1[k][C] ? neg_s1[k][C-1:0] : diff_s1[k][C-1:0];
		end
		ok_s1 = pt_present && ((qmask_q == '0) || ((pt_flags & qmask_q) != '0));
	end

	always_ff @(posedge clk) begin
		idx_s1 <= index;
		mag_s2 <= mag_s1;
		ok_s2  <= ok_s1;
		idx_s2 <= idx_s1;
		for (int k = 0; k < 3; k++) begin
			sq_s3[k] <= mag_s2[k] * mag_s2[k];
		end
		ok_s3  <= ok_s2;
		idx_s3 <= idx_s2;
		sum_s4 <= DIST_W'(sq_s3[0]) + DIST_W'(sq_s3[1]) + DIST_W'(sq_s3[2]);
		ok_s4  <= ok_s3;
		idx_s4 <= idx_s3;
	end

	// Query load and best-match update.
	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			qpos_q  <= pos_c;
			qmask_q <= mask_ext[FLAG_BITS-1:0];
			limit_q <= (max_distance == '0) ? DIST_W'(nps_pkg::DEFAULT_LIMIT_SQ)
			                                : DIST_W'(maxd_sq);
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_d_q   <= '0;
		end else if (v_s4 && ok_s4 && (sum_s4 < limit_q)) begin
			limit_q    <= sum_s4;
			found_q    <= 1'b1;
			best_idx_q <= idx_s4;
			best_d_q   <= sum_s4[nps_pkg::DIST_PORT_BITS-1:0];
		end
	end

	logic [31:0] best_idx_ext;

	assign best_idx_ext     = 32'(best_idx_q);
	assign status.scan_done = v_s4 && last_s4;
	assign found            = found_q;
	assign best_slot        = best_idx_ext[nps_pkg::SLOT_PORT_BITS-1:0];
	assign best_dist_sq     = best_d_q;

endmodule
